/* rtl/dwms_pkg.sv */
// Shared types, register indexes and channel helpers for the windowed mean/sigma block.
package dwms_pkg;

   localparam int NCH = 7;
   localparam logic [2:0] CH_LAST = 3'd6;

   localparam int CSR_DATA_W = 16;
   localparam logic CSR_WINDOW_LENGTH = 1'b0;
   localparam logic CSR_DECIMATION = 1'b1;

   localparam logic [13:0] WINDOW_LENGTH_RESET = 14'd8192;
   localparam logic [15:0] DECIMATION_RESET = 16'd1;

   typedef struct packed {
      logic signed [31:0] amp_a;
      logic signed [31:0] amp_b;
      logic signed [31:0] amp_c;
      logic signed [31:0] amp_d;
      logic signed [31:0] sum_signal;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic               clear;
   } req_type;

   typedef struct packed {
      logic [2:0]         channel;
      logic signed [31:0] mean;
      logic [31:0]        sigma;
      logic [13:0]        count;
      logic               last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SUM,
      ST_MDIV,
      ST_DEV,
      ST_VDIV,
      ST_SQRT,
      ST_EMIT
   } back_state_type;

   function automatic logic signed [31:0] channel_sample(req_type r, logic [2:0] ch);
      logic signed [31:0] s;
      case (ch)
         3'd0: s = r.amp_a;
         3'd1: s = r.amp_b;
         3'd2: s = r.amp_c;
         3'd3: s = r.amp_d;
         3'd4: s = r.sum_signal;
         3'd5: s = r.pos_x;
         default: s = r.pos_y;
      endcase
      return s;
   endfunction

endpackage

/* rtl/dwms_fifo.sv */
// Small show-ahead queue used for the job queue and the result queue.
module dwms_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/dwms_front.sv */
// Front end: config registers, clear and decimation bookkeeping, job issue.
module dwms_front #(
   parameter int WINDOW_MAX = 8192,
   parameter int PW = 13,
   parameter int CW = 14
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic                                  csr_index,
   input  logic [dwms_pkg::CSR_DATA_W-1:0]       csr_wr_data,
   input  logic                                  req_push,
   input  dwms_pkg::req_type                     req_data,
   output logic                                  req_full,
   input  logic                                  job_full,
   output logic                                  job_push,
   output logic                                  job_keep,
   output logic [PW-1:0]                         job_slot,
   output logic [CW-1:0]                         job_count
);

   localparam int LW = (CW > 14) ? CW : 14;

   logic [13:0]   wl_ff, wl_in;
   logic [15:0]   dec_ff, dec_in;
   logic [PW-1:0] wp_ff, wp_in;
   logic [CW-1:0] sc_ff, sc_in;
   logic [15:0]   ph_ff, ph_in;

   logic          take;
   logic [PW-1:0] wp0;
   logic [CW-1:0] sc0;
   logic [15:0]   ph0;
   logic [16:0]   ph1;
   logic [15:0]   dec_eff;
   logic [LW-1:0] wl_eff;

   assign req_full = job_full;
   assign take     = req_push && !job_full;
   assign job_push = take;

   always_comb begin
      wl_in  = wl_ff;
      dec_in = dec_ff;
      if (csr_wr_en) begin
         case (csr_index)
            dwms_pkg::CSR_WINDOW_LENGTH: wl_in  = csr_wr_data[13:0];
            dwms_pkg::CSR_DECIMATION:    dec_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      wp0 = req_data.clear ? '0 : wp_ff;
      sc0 = req_data.clear ? '0 : sc_ff;
      ph0 = req_data.clear ? '0 : ph_ff;

      job_keep = (ph0 == '0);
      wp_in = wp0;
      sc_in = sc0;
      if (job_keep) begin
         wp_in = (wp0 == PW'(WINDOW_MAX - 1)) ? '0 : wp0 + 1'b1;
         if (sc0 < CW'(WINDOW_MAX)) begin
            sc_in = sc0 + 1'b1;
         end
      end

      // wrap the phase once it reaches the (possibly lowered) decimation
      dec_eff = (dec_ff == '0) ? 16'd1 : dec_ff;
      ph1     = {1'b0, ph0} + 17'd1;
      ph_in   = (ph1 >= {1'b0, dec_eff}) ? '0 : ph1[15:0];

      // newest kept slot
      job_slot = (wp_in == '0) ? PW'(WINDOW_MAX - 1) : wp_in - 1'b1;

      if (wl_ff == '0) begin
         wl_eff = LW'(1);
      end else if (LW'(wl_ff) > LW'(WINDOW_MAX)) begin
         wl_eff = LW'(WINDOW_MAX);
      end else begin
         wl_eff = LW'(wl_ff);
      end
      job_count = (wl_eff < LW'(sc_in)) ? CW'(wl_eff) : sc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff  <= dwms_pkg::WINDOW_LENGTH_RESET;
         dec_ff <= dwms_pkg::DECIMATION_RESET;
         wp_ff  <= '0;
         sc_ff  <= '0;
         ph_ff  <= '0;
      end else begin
         wl_ff  <= wl_in;
         dec_ff <= dec_in;
         if (take) begin
            wp_ff <= wp_in;
            sc_ff <= sc_in;
            ph_ff <= ph_in;
         end
      end
   end

endmodule

/* rtl/dwms_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module dwms_div #(
   parameter int NW = 78,
   parameter int DW = 14
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] quotient
);

   localparam int CNT_W = $clog2(NW + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [NW-1:0]    quo_ff, quo_in;
   logic [DW:0]      shifted;
   logic [DW:0]      diff;
   logic             ge;

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      shifted = {rem_ff, quo_ff[NW-1]};
      diff    = shifted - {1'b0, divisor};
      ge      = (shifted >= {1'b0, divisor});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NW);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DW-1:0] : shifted[DW-1:0];
         quo_in = {quo_ff[NW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

endmodule

/* rtl/dwms_back.sv */
// Back end: sample store, window walks, mean/variance division and square root.
module dwms_back #(
   parameter int WINDOW_MAX = 8192,
   parameter int SAMPLE_WIDTH = 32,
   parameter int PW = 13,
   parameter int CW = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_empty,
   input  dwms_pkg::req_type     job_sample,
   input  logic                  job_keep,
   input  logic [PW-1:0]         job_slot,
   input  logic [CW-1:0]         job_count,
   output logic                  job_pop,
   input  logic                  rsp_full,
   output logic                  rsp_push,
   output dwms_pkg::rsp_type     rsp_item
);

   localparam int SW   = SAMPLE_WIDTH;
   localparam int AW   = $clog2(dwms_pkg::NCH * WINDOW_MAX);
   localparam int SUMW = SW + CW;
   localparam int ACCW = 2 * SW + CW;
   localparam int NW   = (ACCW > SUMW) ? ACCW : SUMW;
   localparam int MNW  = SW + 1;
   localparam int MW   = ((SW > 32) ? SW : 32) + 1;
   localparam int EW   = ((SW + 1) > 33) ? (SW + 1) : 33;
   localparam int QX   = (NW > 64) ? NW : 65;

   localparam logic signed [MW-1:0] SMAX = {{(MW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
   localparam logic signed [MW-1:0] SMIN = ~SMAX;
   localparam logic signed [EW-1:0] MEAN_HI = EW'(33'sh0_7fff_ffff);
   localparam logic signed [EW-1:0] MEAN_LO = EW'(33'sh1_8000_0000);

   dwms_pkg::back_state_type state_ff, state_in;

   logic [SW-1:0]       mem [dwms_pkg::NCH * WINDOW_MAX];
   logic [2:0]          ch_ff;
   logic [PW-1:0]       rd_ptr_ff;
   logic [CW-1:0]       issued_ff;
   logic signed [SW-1:0] rd_data_ff;
   logic                rvld_ff, dvld_ff, svld_ff;
   logic [SW-1:0]       dm_ff;
   logic [2*SW-1:0]     sq_ff;
   logic signed [SUMW-1:0] sum_ff;
   logic [ACCW-1:0]     acc_ff;
   logic                neg_ff;
   logic signed [MNW-1:0] mean_ff;
   logic                big_ff;
   logic [63:0]         v_ff, res_ff, bit_ff;

   logic                mem_we;
   logic [AW-1:0]       waddr, raddr;
   logic [SW-1:0]       wdata;
   logic signed [MW-1:0] sx;
   logic                issue, walk_start, walk_done;
   logic                div_start, div_done;
   logic [NW-1:0]       div_operand, div_quotient;
   logic [SUMW-1:0]     sum_mag;
   logic signed [MNW:0] dev;
   logic [MNW:0]        dev_mag;
   logic [QX-1:0]       qx;
   logic [63:0]         trial;
   logic signed [EW-1:0] mean_ext;

   assign waddr = AW'(ch_ff) * AW'(WINDOW_MAX) + AW'(job_slot);
   assign raddr = AW'(ch_ff) * AW'(WINDOW_MAX) + AW'(rd_ptr_ff);
   assign walk_done = (issued_ff == job_count) && !rvld_ff && !dvld_ff && !svld_ff;

   // saturate to the stored sample width
   always_comb begin
      sx = MW'(dwms_pkg::channel_sample(job_sample, ch_ff));
      if (sx > SMAX) begin
         wdata = SW'(SMAX);
      end else if (sx < SMIN) begin
         wdata = SW'(SMIN);
      end else begin
         wdata = SW'(sx);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dwms_pkg::ST_IDLE: begin
            if (!job_empty) begin
               state_in = job_keep ? dwms_pkg::ST_WRITE : dwms_pkg::ST_SUM;
            end
         end
         dwms_pkg::ST_WRITE: begin
            if (ch_ff == dwms_pkg::CH_LAST) state_in = dwms_pkg::ST_SUM;
         end
         dwms_pkg::ST_SUM:  if (walk_done) state_in = dwms_pkg::ST_MDIV;
         dwms_pkg::ST_MDIV: if (div_done)  state_in = dwms_pkg::ST_DEV;
         dwms_pkg::ST_DEV:  if (walk_done) state_in = dwms_pkg::ST_VDIV;
         dwms_pkg::ST_VDIV: if (div_done)  state_in = dwms_pkg::ST_SQRT;
         dwms_pkg::ST_SQRT: if (bit_ff == '0) state_in = dwms_pkg::ST_EMIT;
         dwms_pkg::ST_EMIT: begin
            if (!rsp_full) begin
               state_in = (ch_ff == dwms_pkg::CH_LAST) ? dwms_pkg::ST_IDLE : dwms_pkg::ST_SUM;
            end
         end
         default: state_in = dwms_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      mem_we     = (state_ff == dwms_pkg::ST_WRITE);
      issue      = ((state_ff == dwms_pkg::ST_SUM) || (state_ff == dwms_pkg::ST_DEV))
                   && (issued_ff != job_count);
      walk_start = ((state_ff == dwms_pkg::ST_IDLE) && !job_empty && !job_keep)
                   || ((state_ff == dwms_pkg::ST_WRITE) && (ch_ff == dwms_pkg::CH_LAST))
                   || ((state_ff == dwms_pkg::ST_MDIV) && div_done)
                   || ((state_ff == dwms_pkg::ST_EMIT) && !rsp_full
                       && (ch_ff != dwms_pkg::CH_LAST));
      div_start  = ((state_ff == dwms_pkg::ST_SUM) || (state_ff == dwms_pkg::ST_DEV))
                   && walk_done;
      sum_mag    = sum_ff[SUMW-1] ? SUMW'(-sum_ff) : SUMW'(sum_ff);
      div_operand = (state_ff == dwms_pkg::ST_SUM) ? NW'(sum_mag) : NW'(acc_ff);
      rsp_push   = (state_ff == dwms_pkg::ST_EMIT) && !rsp_full;
      job_pop    = rsp_push && (ch_ff == dwms_pkg::CH_LAST);
   end

   always_comb begin
      dev      = (MNW + 1)'(rd_data_ff) - (MNW + 1)'(mean_ff);
      dev_mag  = dev[MNW] ? (MNW + 1)'(-dev) : (MNW + 1)'(dev);
      qx       = QX'(div_quotient);
      trial    = res_ff + bit_ff;
      mean_ext = EW'(mean_ff);

      rsp_item.channel = ch_ff;
      rsp_item.count   = 14'(job_count);
      rsp_item.last    = (ch_ff == dwms_pkg::CH_LAST);
      if (job_count == '0) begin
         rsp_item.mean  = '0;
         rsp_item.sigma = '0;
      end else begin
         if (mean_ext > MEAN_HI) begin
            rsp_item.mean = 32'sh7fff_ffff;
         end else if (mean_ext < MEAN_LO) begin
            rsp_item.mean = 32'sh8000_0000;
         end else begin
            rsp_item.mean = 32'(mean_ext);
         end
         rsp_item.sigma = big_ff ? 32'hffff_ffff : res_ff[31:0];
      end
   end

   dwms_div #(
      .NW(NW),
      .DW(CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_operand),
      .divisor  (job_count),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      rd_data_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dwms_pkg::ST_IDLE;
         rvld_ff  <= 1'b0;
         dvld_ff  <= 1'b0;
         svld_ff  <= 1'b0;
         ch_ff    <= '0;
      end else begin
         state_ff <= state_in;
         rvld_ff  <= issue;
         dvld_ff  <= rvld_ff && (state_ff == dwms_pkg::ST_DEV);
         svld_ff  <= dvld_ff;
         if (state_ff == dwms_pkg::ST_IDLE) begin
            ch_ff <= '0;
         end else if (mem_we) begin
            ch_ff <= (ch_ff == dwms_pkg::CH_LAST) ? '0 : ch_ff + 1'b1;
         end else if (rsp_push && (ch_ff != dwms_pkg::CH_LAST)) begin
            ch_ff <= ch_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      // walk the window from the newest slot back
      if (walk_start) begin
         rd_ptr_ff <= job_slot;
         issued_ff <= '0;
         sum_ff    <= '0;
         acc_ff    <= '0;
      end else begin
         if (issue) begin
            rd_ptr_ff <= (rd_ptr_ff == '0) ? PW'(WINDOW_MAX - 1) : rd_ptr_ff - 1'b1;
            issued_ff <= issued_ff + 1'b1;
         end
         if (rvld_ff && (state_ff == dwms_pkg::ST_SUM)) begin
            sum_ff <= sum_ff + SUMW'(rd_data_ff);
         end
         if (svld_ff && (state_ff == dwms_pkg::ST_DEV)) begin
            acc_ff <= acc_ff + ACCW'(sq_ff);
         end
      end

      dm_ff <= SW'(dev_mag);
      sq_ff <= dm_ff * dm_ff;

      if ((state_ff == dwms_pkg::ST_SUM) && div_start) begin
         neg_ff <= sum_ff[SUMW-1];
      end
      if ((state_ff == dwms_pkg::ST_MDIV) && div_done) begin
         mean_ff <= neg_ff ? -MNW'(div_quotient) : MNW'(div_quotient);
      end

      if ((state_ff == dwms_pkg::ST_VDIV) && div_done) begin
         big_ff <= |qx[QX-1:64];
         v_ff   <= qx[63:0];
         res_ff <= '0;
         bit_ff <= 64'h4000_0000_0000_0000;
      end else if ((state_ff == dwms_pkg::ST_SQRT) && (bit_ff != '0)) begin
         if (v_ff >= trial) begin
            v_ff   <= v_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

endmodule

/* rtl/decimated_window_mean_sigma.sv */
// Usage: decimated seven-channel sample stream in, windowed mean and sigma per channel out.
// The request side is a queue input: drive req_data and push while full is low; each beat
// is one seven-channel sample with a clear flag that empties the store first.
// The response side is a queue output: while empty is low rsp_data holds the oldest
// result; pop takes it. Every sample yields seven beats, channel 0 first, last on channel 6.
// window_length and decimation are written through csr_wr_en/csr_index/csr_wr_data
// while the block is idle; they take effect at once.
// Processing: the back end walks the window twice per channel through one memory read
// port, then runs a bit-serial divider twice and a 32-step square root; a kept sample
// first takes seven store writes, one per channel.
// A two-entry job queue lets the front accept new samples while the back works; an
// eight-entry result queue holds finished beats, and a stalled receiver stalls the back.
// Reset clears pointers, counts and phase and loads the config register defaults; the
// sample store is not cleared and never read before it is written.
module decimated_window_mean_sigma #(
   parameter int WINDOW_MAX = 8192,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic                              csr_index,
   input  logic [dwms_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   input  logic                              push,
   input  dwms_pkg::req_type                 req_data,
   output logic                              full,
   input  logic                              pop,
   output dwms_pkg::rsp_type                 rsp_data,
   output logic                              empty
);

   localparam int PW = $clog2(WINDOW_MAX);
   localparam int CW = $clog2(WINDOW_MAX + 1);
   localparam int RQW = $bits(dwms_pkg::req_type);
   localparam int JW = RQW + 1 + PW + CW;
   localparam int RSW = $bits(dwms_pkg::rsp_type);

   logic          job_push, job_full, job_pop, job_empty;
   logic          f_keep;
   logic [PW-1:0] f_slot;
   logic [CW-1:0] f_count;
   logic [JW-1:0] job_in, job_out;
   dwms_pkg::req_type b_sample;
   logic          b_keep;
   logic [PW-1:0] b_slot;
   logic [CW-1:0] b_count;
   logic          rsp_push, rsp_full;
   dwms_pkg::rsp_type rsp_item;
   logic [RSW-1:0] rsp_vec;

   dwms_front #(
      .WINDOW_MAX(WINDOW_MAX),
      .PW(PW),
      .CW(CW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_push    (push),
      .req_data    (req_data),
      .req_full    (full),
      .job_full    (job_full),
      .job_push    (job_push),
      .job_keep    (f_keep),
      .job_slot    (f_slot),
      .job_count   (f_count)
   );

   assign job_in = {req_data, f_keep, f_slot, f_count};
   assign {b_sample, b_keep, b_slot, b_count} = job_out;

   dwms_fifo #(
      .WIDTH(JW),
      .DEPTH(2)
   ) u_job_q (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_out),
      .empty     (job_empty)
   );

   dwms_back #(
      .WINDOW_MAX(WINDOW_MAX),
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .PW(PW),
      .CW(CW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_empty  (job_empty),
      .job_sample (b_sample),
      .job_keep   (b_keep),
      .job_slot   (b_slot),
      .job_count  (b_count),
      .job_pop    (job_pop),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_item   (rsp_item)
   );

   dwms_fifo #(
      .WIDTH(RSW),
      .DEPTH(8)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_item),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_vec),
      .empty     (empty)
   );

   assign rsp_data = rsp_vec;

endmodule
